// File: rtl/tlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlm_pkg: shared types and constants of the trie tokenizer
// Widths, store depths, command and result codes, and the memory request
// bundle that the control logic hands to the trie store.
// ----------------------------------------------------------------------------
package tlm_pkg;

  localparam int NODE_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int CT_AW      = NODE_W + BYTE_W;
  localparam int CT_DEPTH   = 1 << CT_AW;
  localparam int CNT_W      = NODE_W + 1;
  localparam int TOK_W      = 11;
  localparam int KIND_W     = 2;
  localparam int CMD_W      = 2;

  localparam logic [CNT_W-1:0] MAX_NODES  = CNT_W'(1024);
  localparam logic [CNT_W-1:0] MAX_TOKENS = CNT_W'(1024);
  localparam int NT_DEPTH = 1 << NODE_W;

  typedef logic [NODE_W-1:0]       node_t;
  typedef logic [CT_AW-1:0]        ct_addr_t;
  typedef logic signed [TOK_W-1:0] tok_t;
  typedef logic [KIND_W-1:0]       kind_t;
  typedef logic [CMD_W-1:0]        cmd_t;

  localparam tok_t  TOK_NONE  = '1;
  localparam node_t NODE_ROOT = '0;

  localparam cmd_t CMD_VOCAB_BYTE = 2'd0;
  localparam cmd_t CMD_VOCAB_END  = 2'd1;
  localparam cmd_t CMD_TEXT_BYTE  = 2'd2;
  localparam cmd_t CMD_TEXT_END   = 2'd3;

  localparam kind_t KIND_TOKEN = 2'd0;
  localparam kind_t KIND_DROP  = 2'd1;
  localparam kind_t KIND_END   = 2'd2;
  localparam kind_t KIND_OVF   = 2'd3;

  typedef struct packed {
    logic     ct_we;
    ct_addr_t ct_waddr;
    node_t    ct_wdata;
    ct_addr_t ct_raddr;
    logic     nt_we;
    node_t    nt_waddr;
    tok_t     nt_wdata;
    node_t    nt_raddr;
  } mem_req_t;

endpackage

// File: rtl/tlm_trie_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlm_trie_mem: trie storage
// Child table (node, byte) -> child node and per-node token number, each a
// one-write, one-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module tlm_trie_mem (
  input  logic              clk,
  input  tlm_pkg::mem_req_t req,
  output tlm_pkg::node_t    ct_rdata_r,
  output tlm_pkg::tok_t     nt_rdata_r
);

  tlm_pkg::node_t ct_mem [tlm_pkg::CT_DEPTH];
  tlm_pkg::tok_t  nt_mem [tlm_pkg::NT_DEPTH];

  always_ff @(posedge clk) begin
    if (req.ct_we) begin
      ct_mem[req.ct_waddr] <= req.ct_wdata;
    end
    ct_rdata_r <= ct_mem[req.ct_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.nt_we) begin
      nt_mem[req.nt_waddr] <= req.nt_wdata;
    end
    nt_rdata_r <= nt_mem[req.nt_raddr];
  end

endmodule

// File: rtl/trie_longest_match_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_longest_match_tokenizer: greedy longest-match byte tokenizer
// Builds a byte trie from vocabulary transfers and splits text into tokens.
// ----------------------------------------------------------------------------
// Usage. The input stream carries one command per transfer: a vocabulary
// byte, a vocabulary token end, a text byte or a text end. The output stream
// carries zero, one or two results per command; tlast marks the final result
// of a command, tuser says whether it is a token, a dropped byte, the end of
// text or a store overflow, and tdata holds the token number (-1 if none).
// Timing. Every command costs one child-table read: a command is taken in,
// the read returns the next cycle and the trie and cursors are updated
// then. A text byte that falls off the trie needs a second read at the
// root, and each result passes through the emit state. The single read
// port of the child table sets this pace; one command is in flight at a
// time.
// Reset. After rst_n the block sweeps the child table, one entry a cycle,
// clearing 262144 entries (and presetting the 1024 node tokens to -1 along
// the way); in_tready stays low until the sweep is done.
// Stall. A result waits in the output register while out_tready is low;
// the block holds a further result in the emit state, taking no command.
// ----------------------------------------------------------------------------
module trie_longest_match_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] cmd, [9:2] byte_req, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] token number, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last result of the command
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_LOOK  = 3'd2;
  localparam logic [ST_W-1:0] ST_ROOT  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMIT  = 3'd4;

  localparam int PAD_W = 16 - tlm_pkg::TOK_W;

  logic [ST_W-1:0]          state_r, state_nxt;
  tlm_pkg::node_t           text_node_r, text_node_nxt;
  tlm_pkg::node_t           build_node_r, build_node_nxt;
  logic [tlm_pkg::CNT_W-1:0] free_node_r, free_node_nxt;
  logic [tlm_pkg::CNT_W-1:0] token_count_r, token_count_nxt;
  tlm_pkg::ct_addr_t        clr_cnt_r, clr_cnt_nxt;

  // Command being worked on.
  tlm_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [tlm_pkg::BYTE_W-1:0] byte_r, byte_nxt;

  // Result waiting to be emitted, plus an optional trailing marker result.
  tlm_pkg::tok_t            res_tok_r, res_tok_nxt;
  tlm_pkg::kind_t           res_kind_r, res_kind_nxt;
  logic                     res_last_r, res_last_nxt;
  logic                     second_r, second_nxt;
  tlm_pkg::kind_t           sec_kind_r, sec_kind_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  tlm_pkg::tok_t            out_tok_r, out_tok_nxt;
  tlm_pkg::kind_t           out_kind_r, out_kind_nxt;
  logic                     out_last_r, out_last_nxt;

  tlm_pkg::mem_req_t        req;
  tlm_pkg::node_t           ct_q;
  tlm_pkg::tok_t            nt_q;
  logic                     slot_free;
  tlm_pkg::cmd_t            in_cmd;
  logic [tlm_pkg::BYTE_W-1:0] in_byte;

  assign in_cmd    = in_tdata[tlm_pkg::CMD_W-1:0];
  assign in_byte   = in_tdata[tlm_pkg::CMD_W +: tlm_pkg::BYTE_W];
  assign slot_free = !out_valid_r || out_tready;

  tlm_trie_mem u_mem (
    .clk        (clk),
    .req        (req),
    .ct_rdata_r (ct_q),
    .nt_rdata_r (nt_q)
  );

  always_comb begin
    state_nxt       = state_r;
    text_node_nxt   = text_node_r;
    build_node_nxt  = build_node_r;
    free_node_nxt   = free_node_r;
    token_count_nxt = token_count_r;
    clr_cnt_nxt     = clr_cnt_r;
    cmd_nxt         = cmd_r;
    byte_nxt        = byte_r;
    res_tok_nxt     = res_tok_r;
    res_kind_nxt    = res_kind_r;
    res_last_nxt    = res_last_r;
    second_nxt      = second_r;
    sec_kind_nxt    = sec_kind_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_tok_nxt     = out_tok_r;
    out_kind_nxt    = out_kind_r;
    out_last_nxt    = out_last_r;

    // The node-token read always follows the text cursor, so the pending
    // token is on hand whenever a text command needs to flush it.
    req.ct_we    = 1'b0;
    req.ct_waddr = {build_node_r, byte_r};
    req.ct_wdata = free_node_r[tlm_pkg::NODE_W-1:0];
    req.ct_raddr = {text_node_r, byte_r};
    req.nt_we    = 1'b0;
    req.nt_waddr = build_node_r;
    req.nt_wdata = tlm_pkg::tok_t'(token_count_r);
    req.nt_raddr = text_node_r;

    unique case (state_r)
      ST_CLEAR: begin
        req.ct_we    = 1'b1;
        req.ct_waddr = clr_cnt_r;
        req.ct_wdata = tlm_pkg::NODE_ROOT;
        req.nt_we    = (clr_cnt_r[tlm_pkg::CT_AW-1:tlm_pkg::NODE_W] == '0);
        req.nt_waddr = clr_cnt_r[tlm_pkg::NODE_W-1:0];
        req.nt_wdata = tlm_pkg::TOK_NONE;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_cmd == tlm_pkg::CMD_TEXT_BYTE) begin
          req.ct_raddr = {text_node_r, in_byte};
        end else begin
          req.ct_raddr = {build_node_r, in_byte};
        end
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          byte_nxt  = in_byte;
          state_nxt = ST_LOOK;
        end
      end

      ST_LOOK: begin
        // ct_q holds the child of the addressed cursor for byte_r.
        res_tok_nxt  = tlm_pkg::TOK_NONE;
        res_last_nxt = 1'b1;
        second_nxt   = 1'b0;
        state_nxt    = ST_IDLE;
        unique case (cmd_r)
          tlm_pkg::CMD_VOCAB_BYTE: begin
            if (ct_q != tlm_pkg::NODE_ROOT) begin
              build_node_nxt = ct_q;
            end else if (free_node_r < tlm_pkg::MAX_NODES) begin
              req.ct_we      = 1'b1;
              build_node_nxt = free_node_r[tlm_pkg::NODE_W-1:0];
              free_node_nxt  = free_node_r + 1'b1;
            end else begin
              res_kind_nxt = tlm_pkg::KIND_OVF;
              state_nxt    = ST_EMIT;
            end
          end
          tlm_pkg::CMD_VOCAB_END: begin
            build_node_nxt = tlm_pkg::NODE_ROOT;
            if (token_count_r < tlm_pkg::MAX_TOKENS) begin
              req.nt_we       = 1'b1;
              token_count_nxt = token_count_r + 1'b1;
            end else begin
              res_kind_nxt = tlm_pkg::KIND_OVF;
              state_nxt    = ST_EMIT;
            end
          end
          tlm_pkg::CMD_TEXT_BYTE: begin
            if (ct_q != tlm_pkg::NODE_ROOT) begin
              text_node_nxt = ct_q;
            end else if (text_node_r != tlm_pkg::NODE_ROOT) begin
              // Fell off the trie: retry the byte at the root.
              req.ct_raddr = {tlm_pkg::NODE_ROOT, byte_r};
              state_nxt    = ST_ROOT;
            end else begin
              res_kind_nxt = tlm_pkg::KIND_DROP;
              state_nxt    = ST_EMIT;
            end
          end
          tlm_pkg::CMD_TEXT_END: begin
            text_node_nxt = tlm_pkg::NODE_ROOT;
            state_nxt     = ST_EMIT;
            if (text_node_r != tlm_pkg::NODE_ROOT) begin
              res_tok_nxt  = nt_q;
              res_kind_nxt = tlm_pkg::KIND_TOKEN;
              res_last_nxt = 1'b0;
              second_nxt   = 1'b1;
              sec_kind_nxt = tlm_pkg::KIND_END;
            end else begin
              res_kind_nxt = tlm_pkg::KIND_END;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_ROOT: begin
        // nt_q is the token of the abandoned walk, ct_q the root child.
        res_tok_nxt   = nt_q;
        res_kind_nxt  = tlm_pkg::KIND_TOKEN;
        res_last_nxt  = (ct_q != tlm_pkg::NODE_ROOT);
        second_nxt    = (ct_q == tlm_pkg::NODE_ROOT);
        sec_kind_nxt  = tlm_pkg::KIND_DROP;
        text_node_nxt = ct_q;
        state_nxt     = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tok_nxt   = res_tok_r;
          out_kind_nxt  = res_kind_r;
          out_last_nxt  = res_last_r;
          if (second_r) begin
            res_tok_nxt  = tlm_pkg::TOK_NONE;
            res_kind_nxt = sec_kind_r;
            res_last_nxt = 1'b1;
            second_nxt   = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      text_node_r   <= tlm_pkg::NODE_ROOT;
      build_node_r  <= tlm_pkg::NODE_ROOT;
      free_node_r   <= tlm_pkg::CNT_W'(1);
      token_count_r <= '0;
      clr_cnt_r     <= '0;
      second_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      text_node_r   <= text_node_nxt;
      build_node_r  <= build_node_nxt;
      free_node_r   <= free_node_nxt;
      token_count_r <= token_count_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      second_r      <= second_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    byte_r     <= byte_nxt;
    res_tok_r  <= res_tok_nxt;
    res_kind_r <= res_kind_nxt;
    res_last_r <= res_last_nxt;
    sec_kind_r <= sec_kind_nxt;
    out_tok_r  <= out_tok_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_tok_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
